>>> hw/rtl/cbn_pkg.sv
package cbn_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_OPEN    = 2'd1;
    localparam logic [1:0] OP_CLOSE   = 2'd2;

    localparam int unsigned CFG_BITS  = 6;
    // Wide enough for a fill count of the largest supported buffer depth.
    localparam int unsigned FILL_BITS = 7;

    // One finished batch handed from the front to the back.
    typedef struct packed {
        logic                 bank;
        logic [FILL_BITS-1:0] count;
        logic                 ovf;
    } t_desc;

    // The back returns a bank to the front once it has drained it.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

>>> hw/rtl/command_batcher_nested_blocks_unit.sv
// A completed batch passes through the descriptor queue to the back, which shows each word
// after the registered memory read (S_READ) and then the output stage (S_SHOW); the
// consumer may stall any word.
// Throughput: one input item per cycle while a bank is free; two banks alternate, so
// the front stalls only when both hold batches not yet fully drained.
// Reset: synchronous, active low; batch_size returns to 3, sized mode, empty buffers.
module command_batcher_nested_blocks_unit #(
    parameter int unsigned BUFFER_DEPTH = 32,
    parameter int unsigned WORD_BITS    = 32,
    parameter int unsigned NEST_BITS    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cbn_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_op,
    input  logic [WORD_BITS-1:0]         i_command_word,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [WORD_BITS-1:0]         o_batch_word,
    output logic                         o_last_of_batch,
    output logic                         o_truncated
);

    logic                          wr_en;
    logic [$clog2(BUFFER_DEPTH):0] wr_addr;
    logic [WORD_BITS-1:0]          wr_data;
    logic                          push;
    logic                          pop;
    logic                          q_nonempty;
    cbn_pkg::t_desc                desc_in;
    cbn_pkg::t_desc                desc_out;
    cbn_pkg::t_release             release_bank;

    cbn_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .WORD_BITS    (WORD_BITS),
        .NEST_BITS    (NEST_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_command_word (i_command_word),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_push         (push),
        .o_desc         (desc_in),
        .i_release      (release_bank)
    );

    cbn_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_desc     (desc_in),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_desc     (desc_out)
    );

    cbn_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .WORD_BITS    (WORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (wr_en),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (wr_data),
        .i_q_nonempty    (q_nonempty),
        .i_desc          (desc_out),
        .o_pop           (pop),
        .o_release       (release_bank),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_batch_word    (o_batch_word),
        .o_last_of_batch (o_last_of_batch),
        .o_truncated     (o_truncated)
    );

endmodule

>>> hw/rtl/cbn_queue.sv
module cbn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cbn_pkg::t_desc i_desc,
    input  logic          i_pop,
    output logic          o_nonempty,
    output cbn_pkg::t_desc o_desc
);

    cbn_pkg::t_desc r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    assign o_nonempty = (r_cnt != 2'd0);
    assign o_desc     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push || i_pop)
        else $error("descriptor queue overrun");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("descriptor queue underrun");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("descriptor queue count out of range");
`endif

endmodule

>>> hw/rtl/cbn_front.sv
module cbn_front #(
    parameter int unsigned BUFFER_DEPTH = 32,
    parameter int unsigned WORD_BITS    = 32,
    parameter int unsigned NEST_BITS    = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbn_pkg::CFG_BITS-1:0]        i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [WORD_BITS-1:0]                i_command_word,
    output logic                                o_wr_en,
    output logic [$clog2(BUFFER_DEPTH):0]       o_wr_addr,
    output logic [WORD_BITS-1:0]                o_wr_data,
    output logic                                o_push,
    output cbn_pkg::t_desc                      o_desc,
    input  cbn_pkg::t_release                   i_release
);

    localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned LW    = (CNT_W > cbn_pkg::CFG_BITS) ? CNT_W : cbn_pkg::CFG_BITS;

    logic [cbn_pkg::CFG_BITS-1:0] r_batch_size;
    logic                         r_dyn,   n_dyn;
    logic [NEST_BITS-1:0]         r_nest,  n_nest;
    logic [CNT_W-1:0]             r_fill,  n_fill;
    logic                         r_ovf,   n_ovf;
    logic                         r_bank,  n_bank;
    logic [1:0]                   r_busy,  n_busy;

    logic             accept;
    logic             push_ok;
    logic             do_flush;
    logic [CNT_W-1:0] cnt_after;
    logic             ovf_after;
    logic [LW-1:0]    limit;

    assign o_ready   = !r_busy[r_bank];
    assign accept    = i_valid && o_ready;
    assign push_ok   = (r_fill < CNT_W'(BUFFER_DEPTH));
    assign o_wr_addr = {r_bank, r_fill[AW-1:0]};
    assign o_wr_data = i_command_word;

    // Effective sized-mode limit: zero acts as one, and the buffer depth caps it.
    always_comb begin
        if (r_batch_size == '0) begin
            limit = LW'(1);
        end else if (LW'(r_batch_size) > LW'(BUFFER_DEPTH)) begin
            limit = LW'(BUFFER_DEPTH);
        end else begin
            limit = LW'(r_batch_size);
        end
    end

    always_comb begin
        n_dyn     = r_dyn;
        n_nest    = r_nest;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_bank    = r_bank;
        n_busy    = r_busy;
        o_wr_en   = 1'b0;
        do_flush  = 1'b0;
        cnt_after = r_fill;
        ovf_after = r_ovf;
        o_push    = 1'b0;

        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            unique case (i_op)
                cbn_pkg::OP_COMMAND: begin
                    if (push_ok) begin
                        o_wr_en   = 1'b1;
                        cnt_after = r_fill + CNT_W'(1);
                    end else begin
                        ovf_after = 1'b1;
                    end
                    n_fill = cnt_after;
                    n_ovf  = ovf_after;
                    if (!r_dyn && (LW'(cnt_after) >= limit)) begin
                        do_flush = 1'b1;
                    end
                end
                cbn_pkg::OP_OPEN: begin
                    if (!r_dyn) begin
                        do_flush = 1'b1;
                        n_dyn    = 1'b1;
                        n_nest   = '0;
                    end else if (r_nest != '1) begin
                        n_nest = r_nest + NEST_BITS'(1);
                    end
                end
                cbn_pkg::OP_CLOSE: begin
                    if (r_dyn) begin
                        if (r_nest != '0) begin
                            n_nest = r_nest - NEST_BITS'(1);
                        end else begin
                            n_dyn    = 1'b0;
                            do_flush = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // A flush hands a non-empty bank to the back and moves on to the other bank.
        if (do_flush) begin
            n_fill = '0;
            n_ovf  = 1'b0;
            if (cnt_after != '0) begin
                o_push         = 1'b1;
                n_bank         = ~r_bank;
                n_busy[r_bank] = 1'b1;
            end
        end
    end

    assign o_desc = '{bank: r_bank, count: cbn_pkg::FILL_BITS'(cnt_after), ovf: ovf_after};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_size <= cbn_pkg::CFG_BITS'(3);
            r_dyn        <= 1'b0;
            r_nest       <= '0;
            r_fill       <= '0;
            r_ovf        <= 1'b0;
            r_bank       <= 1'b0;
            r_busy       <= 2'b00;
        end else begin
            if (i_cfg_we) begin
                r_batch_size <= i_cfg_wdata;
            end
            r_dyn  <= n_dyn;
            r_nest <= n_nest;
            r_fill <= n_fill;
            r_ovf  <= n_ovf;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(BUFFER_DEPTH))
        else $error("fill count beyond buffer depth");
    a_sized_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dyn |-> (r_nest == '0) && !r_ovf)
        else $error("nesting or overflow left over in sized mode");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !r_busy[r_bank])
        else $error("write into a bank that is still draining");
`endif

endmodule

>>> hw/rtl/cbn_back.sv
module cbn_back #(
    parameter int unsigned BUFFER_DEPTH = 32,
    parameter int unsigned WORD_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(BUFFER_DEPTH):0] i_wr_addr,
    input  logic [WORD_BITS-1:0]          i_wr_data,
    input  logic                          i_q_nonempty,
    input  cbn_pkg::t_desc                i_desc,
    output logic                          o_pop,
    output cbn_pkg::t_release             o_release,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [WORD_BITS-1:0]          o_batch_word,
    output logic                          o_last_of_batch,
    output logic                          o_truncated
);

    localparam int unsigned AW        = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W     = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned MEM_DEPTH = 2 ** (AW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    t_state           r_state;
    logic             r_bank;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [AW-1:0]    r_idx;
    logic             r_last;
    logic             r_trunc;
    logic             r_rel;

    logic [WORD_BITS-1:0] r_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 at_last;

    assign at_last         = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_pop           = (r_state == S_IDLE) && i_q_nonempty;
    assign o_valid         = (r_state == S_SHOW);
    assign o_batch_word    = r_rdata;
    assign o_last_of_batch = r_last;
    assign o_truncated     = r_trunc;
    assign o_release       = '{valid: r_rel, bank: r_bank};

    // The bank being drained is held busy in the front, so reads never race writes.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[{r_bank, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_trunc <= 1'b0;
            r_rel   <= 1'b0;
        end else begin
            r_rel <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_nonempty) begin
                        r_bank  <= i_desc.bank;
                        r_count <= CNT_W'(i_desc.count);
                        r_ovf   <= i_desc.ovf;
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_last  <= at_last;
                    r_trunc <= at_last && r_ovf;
                    r_state <= S_SHOW;
                end
                S_SHOW: begin
                    if (i_ready) begin
                        if (r_last) begin
                            r_rel   <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (CNT_W'(r_idx) < r_count))
        else $error("drain index past end of batch");
    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_truncated && o_valid |-> o_last_of_batch)
        else $error("truncated flag away from last word");
    a_release_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel |-> $past(o_valid && i_ready && o_last_of_batch))
        else $error("bank released before its last word left");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam int         HOLD_DEPTH   = 32;
    localparam logic [7:0] NEST_TOP     = 8'd255;
    localparam int         ITEM_TARGET  = 310;
    localparam int         SCRIPT_LEN   = 28;
    localparam int         DRAIN_CYCLES = 80;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [5:0]  i_cfg_wdata    = 6'd0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_op           = cbn_pkg::OP_COMMAND;
    logic [31:0] i_command_word = 32'd0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_batch_word;
    logic        o_last_of_batch;
    logic        o_truncated;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        trunc;
    } t_batch_beat;

    // A directed row is either a register write or one input transfer. Where has_tail is
    // set, the final word of the batch that the transfer releases is given by hand.
    typedef struct packed {
        logic        is_cfg;
        logic [5:0]  cfg_value;
        logic [1:0]  op;
        logic [31:0] word;
        logic        has_tail;
        logic [31:0] tail_word;
        logic        tail_trunc;
    } t_stim_row;

    t_stim_row script [SCRIPT_LEN] = '{
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'hFFFF_FFFF, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_CLOSE,   32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  OP_RESERVED,         32'hFFFF_FFFF, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h1234_5678, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_OPEN,    32'hFFFF_FFFF, 1'b1, 32'h1234_5678, 1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_OPEN,    32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h0000_0001, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_CLOSE,   32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_CLOSE,   32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_OPEN,    32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_CLOSE,   32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b1, 6'd0,  cbn_pkg::OP_COMMAND, 32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, 1'b0},
        '{1'b1, 6'd5,  cbn_pkg::OP_COMMAND, 32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h1111_1111, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h2222_2222, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h3333_3333, 1'b0, 32'h0,          1'b0},
        '{1'b1, 6'd2,  cbn_pkg::OP_COMMAND, 32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h4444_4444, 1'b1, 32'h4444_4444, 1'b0},
        '{1'b1, 6'd32, cbn_pkg::OP_COMMAND, 32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_OPEN,    32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_COMMAND, 32'h8000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_OPEN,    32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  OP_RESERVED,         32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_CLOSE,   32'h0000_0000, 1'b0, 32'h0,          1'b0},
        '{1'b0, 6'd0,  cbn_pkg::OP_CLOSE,   32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0}
    };

    logic [5:0] size_plan [6] = '{6'd1, 6'd63, 6'd32, 6'd0, 6'd7, 6'd2};

    // Predictor state.
    logic [5:0]  model_size = 6'd3;
    bit          in_block   = 1'b0;
    logic [7:0]  nest_level = 8'd0;
    logic [31:0] held_words [HOLD_DEPTH];
    int          held_count = 0;
    bit          dropped    = 1'b0;

    t_batch_beat words_due [$];

    bit steady          = 1'b0;
    int mismatch_count  = 0;
    int items_accepted  = 0;
    int effective_items = 0;
    int words_checked   = 0;
    int truncated_seen  = 0;
    int cfg_writes      = 0;

    command_batcher_nested_blocks_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_command_word  (i_command_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_batch_word    (o_batch_word),
        .o_last_of_batch (o_last_of_batch),
        .o_truncated     (o_truncated)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic hold_word(input logic [31:0] word);
        if (held_count < HOLD_DEPTH) begin
            held_words[held_count] = word;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic release_held(output int n_beats, output t_batch_beat tail);
        t_batch_beat beat;
        n_beats = held_count;
        tail = '0;
        for (int k = 0; k < held_count; k++) begin
            beat.word  = held_words[k];
            beat.last  = (k == held_count - 1);
            beat.trunc = beat.last && dropped;
            words_due.insert(words_due.size(), beat);
            tail = beat;
        end
        held_count = 0;
        dropped = 1'b0;
    endtask

    task automatic predict_batches(input logic [1:0] op, input logic [31:0] word,
                                   output bit took_effect, output int n_beats,
                                   output t_batch_beat tail);
        int limit;
        took_effect = 1'b1;
        n_beats = 0;
        tail = '0;
        if (!in_block) begin
            case (op)
                cbn_pkg::OP_OPEN: begin
                    release_held(n_beats, tail);
                    in_block = 1'b1;
                    nest_level = 8'd0;
                end
                cbn_pkg::OP_COMMAND: begin
                    // A size of zero acts as one; sizes past the buffer complete when full.
                    limit = (model_size == 6'd0) ? 1 :
                            (model_size > HOLD_DEPTH) ? HOLD_DEPTH : int'(model_size);
                    hold_word(word);
                    if (held_count >= limit) begin
                        release_held(n_beats, tail);
                    end
                end
                default: took_effect = 1'b0;
            endcase
        end else begin
            case (op)
                cbn_pkg::OP_OPEN: begin
                    if (nest_level != NEST_TOP) begin
                        nest_level++;
                    end else begin
                        took_effect = 1'b0;
                    end
                end
                cbn_pkg::OP_CLOSE: begin
                    if (nest_level != 8'd0) begin
                        nest_level--;
                    end else begin
                        in_block = 1'b0;
                        release_held(n_beats, tail);
                    end
                end
                cbn_pkg::OP_COMMAND: hold_word(word);
                default: took_effect = 1'b0;
            endcase
        end
    endtask

    // Presents one item and returns at the falling edge after its transfer.
    task automatic transfer_item(input logic [1:0] op, input logic [31:0] word,
                                 output int n_beats, output t_batch_beat tail);
        bit took_effect;
        if (!steady && $urandom_range(0, 99) < 34) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_command_word <= word;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_batches(op, word, took_effect, n_beats, tail);
        items_accepted++;
        if (took_effect) begin
            effective_items++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [5:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_size = value;
        cfg_writes++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed blocks and sized bursts; some blocks are left open and some
    // items are plain noise.
    task automatic random_sequence();
        int          pick;
        int          n;
        int          depth;
        bit          flood;
        int          nb;
        t_batch_beat tl;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            n = $urandom_range(1, 40);
            repeat (n) transfer_item(cbn_pkg::OP_COMMAND, rand_word(), nb, tl);
        end else if (pick < 85) begin
            transfer_item(cbn_pkg::OP_OPEN, rand_word(), nb, tl);
            depth = 0;
            flood = ($urandom_range(0, 4) == 0);
            n = flood ? $urandom_range(33, 42) : $urandom_range(0, 14);
            repeat (n) begin
                pick = flood ? 9 : $urandom_range(0, 5);
                if (pick == 0) begin
                    transfer_item(cbn_pkg::OP_OPEN, rand_word(), nb, tl);
                    depth++;
                end else if (pick == 1 && depth > 0) begin
                    transfer_item(cbn_pkg::OP_CLOSE, rand_word(), nb, tl);
                    depth--;
                end else begin
                    transfer_item(cbn_pkg::OP_COMMAND, rand_word(), nb, tl);
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                repeat (depth + 1) transfer_item(cbn_pkg::OP_CLOSE, rand_word(), nb, tl);
            end
        end else begin
            repeat ($urandom_range(1, 4)) transfer_item(2'($urandom_range(0, 3)), rand_word(),
                                                        nb, tl);
        end
    endtask

    always @(posedge i_clk) begin : check_output
        t_batch_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_batch_word));
            end else begin
                want = words_due.pop_front();
                words_checked++;
                if (o_truncated) begin
                    truncated_seen++;
                end
                if (o_batch_word !== want.word) begin
                    report_mismatch($sformatf("batch_word %h, expected %h",
                                              o_batch_word, want.word));
                end
                if (o_last_of_batch !== want.last) begin
                    report_mismatch($sformatf("last_of_batch %b, expected %b on word %h",
                                              o_last_of_batch, want.last, want.word));
                end
                if (o_truncated !== want.trunc) begin
                    report_mismatch($sformatf("truncated %b, expected %b on word %h",
                                              o_truncated, want.trunc, want.word));
                end
            end
        end
    end

    initial begin : stimulus
        int          n_beats;
        t_batch_beat tail;
        int          phase;
        int          n_seq;
        logic [5:0]  next_size;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (script[r].is_cfg) begin
                write_size(script[r].cfg_value);
            end else begin
                transfer_item(script[r].op, script[r].word, n_beats, tail);
                if (script[r].has_tail && (n_beats == 0 || tail.word !== script[r].tail_word ||
                                           !tail.last || tail.trunc !== script[r].tail_trunc)) begin
                    report_mismatch($sformatf("directed row %0d releases a different batch", r));
                end
            end
        end

        phase = 0;
        while (items_accepted < ITEM_TARGET) begin
            if (phase < 6) begin
                next_size = size_plan[phase];
            end else if ($urandom_range(0, 3) == 0) begin
                next_size = 6'($urandom_range(0, 63));
            end else begin
                next_size = 6'($urandom_range(1, 32));
            end
            write_size(next_size);
            steady = (phase == 2);
            n_seq = $urandom_range(2, 5);
            for (int s = 0; s < n_seq && items_accepted < ITEM_TARGET; s++) begin
                random_sequence();
            end
            phase++;
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (words_due.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", words_due.size()));
        end

        $display("Run covered %0d input transfers (%0d acted on) and %0d register writes.",
                 items_accepted, effective_items, cfg_writes);
        $display("%0d batch words checked, %0d of them carrying the truncated flag.",
                 words_checked, truncated_seen);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d words still expected", words_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
